@@ rtl/dva_pkg.sv @@
package dva_pkg;

  // Default table size
  localparam int NUM_VECTORS_DEF = 64;

  localparam int HADDR_W = 64;
  localparam int CTX_W   = 64;
  localparam int VIDX_W  = 8;

  // Command codes
  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NO_FREE   = 2'd1,
    STATUS_INVALID   = 2'd2,
    STATUS_NOT_ALLOC = 2'd3
  } status_t;

  // Sequencer states
  typedef enum logic {
    ST_IDLE,
    ST_EXEC
  } state_t;

  // One request beat
  typedef struct packed {
    logic               command;
    logic [HADDR_W-1:0] handler_address;
    logic [CTX_W-1:0]   context_word;
    logic [VIDX_W-1:0]  vector_index;
  } in_beat_t;

  // One result beat
  typedef struct packed {
    status_t            status;
    logic [VIDX_W-1:0]  vector;
    logic               table_write;
    logic [HADDR_W-1:0] entry_handler;
    logic [CTX_W-1:0]   entry_context;
  } out_beat_t;

  // Controller to datapath
  typedef struct packed {
    logic capture;
    logic execute;
  } dva_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
  } dva_stat_t;

endpackage

@@ rtl/dva_if.sv @@
// Request channel
interface dva_in_if import dva_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               command;
  logic [HADDR_W-1:0] handler_address;
  logic [CTX_W-1:0]   context_word;
  logic [VIDX_W-1:0]  vector_index;

  modport source (output valid, command, handler_address, context_word, vector_index,
                  input ready);
  modport sink   (input valid, command, handler_address, context_word, vector_index,
                  output ready);
endinterface

// Result channel
interface dva_out_if import dva_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [VIDX_W-1:0]  vector;
  logic               table_write;
  logic [HADDR_W-1:0] entry_handler;
  logic [CTX_W-1:0]   entry_context;

  modport source (output valid, status, vector, table_write, entry_handler, entry_context,
                  input ready);
  modport sink   (input valid, status, vector, table_write, entry_handler, entry_context,
                  output ready);
endinterface

@@ rtl/dva_ctrl.sv @@
module dva_ctrl import dva_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  input  dva_stat_t stat,
  output dva_cmd_t  cmd
);

  state_t state_r, state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state and commands
  always_comb begin
    state_nxt   = state_r;
    cmd.capture = 1'b0;
    cmd.execute = 1'b0;
    in_ready    = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.capture = 1'b1;
          state_nxt   = ST_EXEC;
        end
      end
      ST_EXEC: begin
        // wait for room in the output register
        if (stat.out_free) begin
          cmd.execute = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule

@@ rtl/dva_datapath.sv @@
module dva_datapath import dva_pkg::*; #(
  parameter int NUM_VECTORS = NUM_VECTORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  dva_cmd_t           cmd,
  output dva_stat_t          stat,
  input  in_beat_t           in_beat,
  input  logic               cfg_we,
  input  logic [HADDR_W-1:0] cfg_wdata,
  output logic               out_valid,
  input  logic               out_ready,
  output out_beat_t          out_beat
);

  localparam int IDX_W = (NUM_VECTORS > 1) ? $clog2(NUM_VECTORS) : 1;

  logic [NUM_VECTORS-1:0] in_use_r, in_use_nxt;
  logic [HADDR_W-1:0]     unused_handler_r;
  in_beat_t               req_r;
  out_beat_t              res_r, res_nxt;
  logic                   out_valid_r;

  logic [NUM_VECTORS-1:0] free_vec;
  logic [NUM_VECTORS-1:0] first_free;
  logic [NUM_VECTORS-1:0] rel_mask;
  logic [IDX_W-1:0]       alloc_idx;
  logic [IDX_W-1:0]       rel_idx;
  logic                   any_free;
  logic                   in_range;
  logic                   rel_used;

  // Lowest free vector: isolate lowest set bit, then encode with OR trees
  assign free_vec   = ~in_use_r;
  assign any_free   = |free_vec;
  assign first_free = free_vec & (~free_vec + NUM_VECTORS'(1));

  always_comb begin
    alloc_idx = '0;
    for (int k = 0; k < IDX_W; k++) begin
      for (int v = 0; v < NUM_VECTORS; v++) begin
        if (((v >> k) & 1) == 1) begin
          alloc_idx[k] = alloc_idx[k] | first_free[v];
        end
      end
    end
  end

  // Release checks
  assign in_range = {1'b0, req_r.vector_index} < 9'(NUM_VECTORS);
  assign rel_idx  = req_r.vector_index[IDX_W-1:0];
  assign rel_used = in_use_r[rel_idx];
  assign rel_mask = NUM_VECTORS'(1) << rel_idx;

  // Result and bitmap update
  always_comb begin
    in_use_nxt = in_use_r;
    res_nxt    = '0;
    if (req_r.command == CMD_ALLOC) begin
      if (!any_free) begin
        res_nxt.status = STATUS_NO_FREE;
      end else begin
        in_use_nxt            = in_use_r | first_free;
        res_nxt.status        = STATUS_OK;
        res_nxt.vector        = VIDX_W'(alloc_idx);
        res_nxt.table_write   = 1'b1;
        res_nxt.entry_handler = req_r.handler_address;
        res_nxt.entry_context = req_r.context_word;
      end
    end else if (!in_range) begin
      res_nxt.status = STATUS_INVALID;
    end else if (!rel_used) begin
      res_nxt.status = STATUS_NOT_ALLOC;
    end else begin
      in_use_nxt            = in_use_r & ~rel_mask;
      res_nxt.status        = STATUS_OK;
      res_nxt.vector        = req_r.vector_index;
      res_nxt.table_write   = 1'b1;
      res_nxt.entry_handler = unused_handler_r;
      res_nxt.entry_context = CTX_W'(req_r.vector_index);
    end
  end

  // Control state: bitmap, config, output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_use_r         <= '0;
      unused_handler_r <= '0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cmd.execute) begin
        in_use_r <= in_use_nxt;
      end
      if (cfg_we) begin
        unused_handler_r <= cfg_wdata;
      end
      if (cmd.execute) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      req_r <= in_beat;
    end
    if (cmd.execute) begin
      res_r <= res_nxt;
    end
  end

  assign stat.out_free = !out_valid_r || out_ready;
  assign out_valid     = out_valid_r;
  assign out_beat      = res_r;

endmodule

@@ rtl/dispatch_vector_allocator.sv @@
// Dispatch vector allocator.
// Request channel in_ch: command (allocate or free), handler address and
// context word for an allocate, vector index for a free. Result channel
// out_ch: one beat per request with status, vector, table write flag and
// the dispatch entry to write. cfg_we/cfg_wdata set the handler that a
// freed vector gets back; write it only while no request is in flight.
// A taken request is captured into a register, and its result is
// registered when it is evaluated. No new request is taken until the last
// is evaluated, as ordered by the two-state sequencer (capture the request,
// then evaluate and update the in-use bitmap); the lowest free vector comes
// from a bit-isolate and encode over the bitmap in the evaluate cycle.
// The result sits in an output register, so a new request is taken while
// the previous result still waits; if the receiver stalls, the next
// evaluation holds until that register drains and in_ch.ready stays low.
// Reset (rst_n low, synchronous) marks every vector free, clears the
// freed-vector handler to zero and empties the output register.
module dispatch_vector_allocator import dva_pkg::*; #(
  parameter int NUM_VECTORS = NUM_VECTORS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               cfg_we,
  input  logic [HADDR_W-1:0] cfg_wdata,
  dva_in_if.sink             in_ch,
  dva_out_if.source          out_ch
);

  dva_cmd_t  cmd;
  dva_stat_t stat;
  in_beat_t  in_beat;
  out_beat_t out_beat;

  assign in_beat.command         = in_ch.command;
  assign in_beat.handler_address = in_ch.handler_address;
  assign in_beat.context_word    = in_ch.context_word;
  assign in_beat.vector_index    = in_ch.vector_index;

  dva_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  dva_datapath #(
    .NUM_VECTORS (NUM_VECTORS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .stat      (stat),
    .in_beat   (in_beat),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_beat  (out_beat)
  );

  assign out_ch.status        = out_beat.status;
  assign out_ch.vector        = out_beat.vector;
  assign out_ch.table_write   = out_beat.table_write;
  assign out_ch.entry_handler = out_beat.entry_handler;
  assign out_ch.entry_context = out_beat.entry_context;

  // A taken request is evaluated before another is taken
  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("request taken while previous one still in evaluation");

  // Every evaluation presents its result on the output channel
  a_result_after_eval: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.execute |=> out_ch.valid)
    else $error("evaluated result not presented");

  // Successful results always carry a table write; failures never do
  a_write_matches_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.table_write == (out_ch.status == STATUS_OK)))
    else $error("table write flag disagrees with status");

endmodule
